@@ rtl/ffba_pkg.sv @@
// ----------------------------------------------------------------------------
// ffba_pkg
// Shared constants, codes and the token word passed along the cell chain.
// ----------------------------------------------------------------------------
package ffba_pkg;

    localparam int BLOCK_COUNT = 64;
    // block size 1 + i*step stays below BLOCK_COUNT * 2^16
    localparam int BS_W        = $clog2(BLOCK_COUNT) + 17;
    localparam int ADDR_W      = 32;
    localparam int STEP_W      = 16;
    localparam int CFG_W       = 32;

    localparam logic [ADDR_W-1:0] BASE_RST = 32'd0;
    localparam logic [STEP_W-1:0] STEP_RST = 16'd16;

    typedef enum logic [1:0] {
        ST_ALLOCATED = 2'd0,
        ST_NO_FIT    = 2'd1,
        ST_FREED     = 2'd2,
        ST_NOT_FOUND = 2'd3
    } status_t;

    typedef enum logic {
        REQ_ALLOC = 1'b0,
        REQ_FREE  = 1'b1
    } req_t;

    typedef enum logic {
        CFG_BASE = 1'b0,
        CFG_STEP = 1'b1
    } cfg_idx_t;

    typedef struct packed {
        logic              live;
        logic              done;
        req_t              kind;
        logic [ADDR_W-1:0] req_size;
        logic [ADDR_W-1:0] rel_addr;
        logic [ADDR_W-1:0] addr;
        logic [BS_W-1:0]   bsize;
        logic [ADDR_W-1:0] granted;
        status_t           status;
    } token_t;

endpackage

@@ rtl/first_fit_block_allocator.sv @@
// ----------------------------------------------------------------------------
// first_fit_block_allocator
// First-fit allocator over a fixed table of blocks with growing sizes.
// ----------------------------------------------------------------------------
// Usage:
//   Input word on s_: s_tuser is the request kind (allocate or free), s_tdata
//   carries the requested size and the address to free. One result word per
//   request leaves on m_: granted address in m_tdata, status in m_tuser.
//   The table is a chain of BLOCK_COUNT cells, one block each; a request word
//   walks one cell per cycle, computing block addresses as it goes.
//   The result passes the BLOCK_COUNT cell registers, a holding register and
//   the output register on its way to m_tvalid. One request is in flight at a
//   time: s_tready drops on accept and rises again once the result enters the
//   output register, so a new request can be taken while the previous result
//   still waits there. If the receiver stalls, the result parks in the holding
//   register and s_tready stays low until the output register takes it.
//   Reset (synchronous, aresetn low) marks every block free and sets the
//   registers to base 0, step 16. Write cfg_* only while no request is open.
// ----------------------------------------------------------------------------
module first_fit_block_allocator
    import ffba_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_we,
    input  logic             cfg_index,
    input  logic [CFG_W-1:0] cfg_data,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [63:0]      s_tdata,   // [31:0] req_size, [63:32] release_addr
    input  logic [0:0]       s_tuser,   // [0] req_type
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [31:0]      m_tdata,   // [31:0] granted_addr
    output logic [1:0]       m_tuser    // [1:0] status
);

    logic [ADDR_W-1:0] base_reg;
    logic [STEP_W-1:0] step_reg;
    logic              busy_reg;
    logic              busy_next;
    logic              hold_valid_reg;
    logic              hold_valid_next;
    logic [ADDR_W-1:0] hold_addr_reg;
    status_t           hold_status_reg;
    logic              m_valid_reg;
    logic [ADDR_W-1:0] m_addr_reg;
    status_t           m_status_reg;
    logic              accept;
    logic              out_free;
    logic              move_out;
    token_t            tok [0:BLOCK_COUNT];
    logic [BLOCK_COUNT-1:0] live_vec;

    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;
    assign move_out = hold_valid_reg && out_free;
    assign s_tready = !busy_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_reg <= BASE_RST;
            step_reg <= STEP_RST;
        end else if (cfg_we) begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_BASE: base_reg <= cfg_data[ADDR_W-1:0];
                CFG_STEP: step_reg <= cfg_data[STEP_W-1:0];
                default:  base_reg <= base_reg;
            endcase
        end
    end

    always_comb begin
        tok[0]          = '0;
        tok[0].live     = accept;
        tok[0].kind     = req_t'(s_tuser[0]);
        tok[0].req_size = s_tdata[31:0];
        tok[0].rel_addr = s_tdata[63:32];
        tok[0].addr     = base_reg;
        tok[0].bsize    = BS_W'(1);
        tok[0].status   = (s_tuser[0] == REQ_FREE) ? ST_NOT_FOUND : ST_NO_FIT;
    end

    for (genvar i = 0; i < BLOCK_COUNT; i++) begin : g_cell
        ffba_cell u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .tok_i   (tok[i]),
            .step_i  (step_reg),
            .tok_o   (tok[i+1])
        );
        assign live_vec[i] = tok[i+1].live;
    end

    always_comb begin
        busy_next = busy_reg;
        if (accept) begin
            busy_next = 1'b1;
        end else if (move_out) begin
            busy_next = 1'b0;
        end
    end

    always_comb begin
        hold_valid_next = hold_valid_reg;
        if (tok[BLOCK_COUNT].live) begin
            hold_valid_next = 1'b1;
        end else if (move_out) begin
            hold_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg       <= 1'b0;
            hold_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            busy_reg       <= busy_next;
            hold_valid_reg <= hold_valid_next;
            if (out_free) begin
                m_valid_reg <= hold_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (tok[BLOCK_COUNT].live) begin
            hold_addr_reg   <= tok[BLOCK_COUNT].granted;
            hold_status_reg <= tok[BLOCK_COUNT].status;
        end
        if (move_out) begin
            m_addr_reg   <= hold_addr_reg;
            m_status_reg <= hold_status_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_addr_reg;
    assign m_tuser  = m_status_reg;

    a_single_word: assert property (@(posedge aclk) disable iff (!aresetn)
        $countones(live_vec) <= 1)
        else $error("more than one request word in the chain");

    a_hold_free: assert property (@(posedge aclk) disable iff (!aresetn)
        tok[BLOCK_COUNT].live |-> !hold_valid_reg)
        else $error("chain result overwrites a parked result");

    a_busy_on_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> busy_reg)
        else $error("request accepted without raising busy");

    a_zero_addr: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser != ST_ALLOCATED) |-> (m_tdata == '0))
        else $error("nonzero address on a result without a grant");

endmodule

@@ rtl/ffba_cell.sv @@
// ----------------------------------------------------------------------------
// ffba_cell
// One table entry: holds the used mark of its block, serves the passing
// request word and hands it on with the next block's address and size.
// ----------------------------------------------------------------------------
module ffba_cell
    import ffba_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  token_t            tok_i,
    input  logic [STEP_W-1:0] step_i,
    output token_t            tok_o
);

    logic   used_reg;
    logic   used_next;
    token_t tok_reg;
    token_t tok_next;
    logic   fits;
    logic   hit;

    always_comb begin
        fits = !used_reg &&
               ({{(ADDR_W-BS_W){1'b0}}, tok_i.bsize} > tok_i.req_size);
        if (tok_i.kind == REQ_FREE) begin
            hit = tok_i.live && !tok_i.done && (tok_i.addr == tok_i.rel_addr);
        end else begin
            hit = tok_i.live && !tok_i.done && fits;
        end
    end

    always_comb begin
        used_next = used_reg;
        if (hit) begin
            used_next = (tok_i.kind == REQ_ALLOC);
        end
    end

    always_comb begin
        tok_next       = tok_i;
        tok_next.addr  = tok_i.addr + {{(ADDR_W-BS_W){1'b0}}, tok_i.bsize};
        tok_next.bsize = tok_i.bsize + {{(BS_W-STEP_W){1'b0}}, step_i};
        if (hit) begin
            tok_next.done = 1'b1;
            if (tok_i.kind == REQ_FREE) begin
                tok_next.status = ST_FREED;
            end else begin
                tok_next.status  = ST_ALLOCATED;
                tok_next.granted = tok_i.addr;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            used_reg     <= 1'b0;
            tok_reg.live <= 1'b0;
        end else begin
            used_reg <= used_next;
            tok_reg  <= tok_next;
        end
    end

    assign tok_o = tok_reg;

endmodule

@@ verif/ffba_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffba_checker
// Watches both stream channels and the register port of the block allocator,
// keeps its own copy of the block table and layout, predicts the reply to
// every accepted request and compares each delivered word against the oldest
// predicted reply.
// ----------------------------------------------------------------------------
module ffba_checker
    import ffba_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_we,
    input  logic             cfg_index,
    input  logic [CFG_W-1:0] cfg_data,
    input  logic             s_tvalid,
    input  logic             s_tready,
    input  logic [63:0]      s_tdata,
    input  logic [0:0]       s_tuser,
    input  logic             m_tvalid,
    input  logic             m_tready,
    input  logic [31:0]      m_tdata,
    input  logic [1:0]       m_tuser,
    output int               fail_count,
    output int               pending
);

    typedef struct {
        logic [ADDR_W-1:0] addr;
        status_t           status;
    } reply_t;

    logic [ADDR_W-1:0] table_base;
    logic [STEP_W-1:0] table_step;
    bit                taken [BLOCK_COUNT];
    reply_t            reply_q[$];
    reply_t            oldest;

    initial fail_count = 0;
    initial pending = 0;

    // first fit on allocate, lowest matching start address on free
    function automatic reply_t serve_request(req_t kind, logic [31:0] want,
                                             logic [31:0] rel);
        reply_t      r;
        logic [31:0] addr;
        logic [63:0] len;
        bit          hit;
        r.addr   = '0;
        r.status = (kind == REQ_ALLOC) ? ST_NO_FIT : ST_NOT_FOUND;
        addr     = table_base;
        hit      = 1'b0;
        for (int i = 0; i < BLOCK_COUNT; i++) begin
            len = 64'd1 + 64'(i) * 64'(table_step);
            if (!hit) begin
                if (kind == REQ_ALLOC) begin
                    if (!taken[i] && len > {32'd0, want}) begin
                        taken[i] = 1'b1;
                        r.addr   = addr;
                        r.status = ST_ALLOCATED;
                        hit      = 1'b1;
                    end
                end else if (addr == rel) begin
                    taken[i] = 1'b0;
                    r.status = ST_FREED;
                    hit      = 1'b1;
                end
            end
            addr = addr + len[31:0];
        end
        return r;
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            table_base = BASE_RST;
            table_step = STEP_RST;
            foreach (taken[i]) taken[i] = 1'b0;
            reply_q.delete();
            pending <= 0;
        end else begin
            if (cfg_we) begin
                if (cfg_index == CFG_BASE) begin
                    table_base = cfg_data[ADDR_W-1:0];
                end else begin
                    table_step = cfg_data[STEP_W-1:0];
                end
            end
            if (s_tvalid && s_tready) begin
                reply_q.push_back(serve_request(req_t'(s_tuser[0]), s_tdata[31:0],
                                                s_tdata[63:32]));
            end
            if (m_tvalid && m_tready) begin
                if (reply_q.size() == 0) begin
                    $error("unexpected word: granted_addr %h status %0d", m_tdata, m_tuser);
                    fail_count++;
                end else begin
                    oldest = reply_q.pop_front();
                    if (m_tdata !== oldest.addr) begin
                        $error("granted_addr: expected %h, actual %h", oldest.addr, m_tdata);
                        fail_count++;
                    end
                    if (m_tuser !== oldest.status) begin
                        $error("status: expected %0d, actual %0d", oldest.status, m_tuser);
                        fail_count++;
                    end
                end
            end
            pending <= reply_q.size();
        end
    end

endmodule

@@ verif/tb_first_fit_block_allocator.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_first_fit_block_allocator
// Drives allocate and free requests into the block allocator over several
// table layouts, with random idling on both sides, a long receiver hold-off
// and a stretch at full rate; the checker beside the block scores every reply.
// ----------------------------------------------------------------------------
module tb_first_fit_block_allocator;
    import ffba_pkg::*;

    localparam int STALL_LIMIT     = 5000;
    localparam int RX_HOLD         = 400;
    localparam int ITEMS_PER_PHASE = 280;

    logic             aclk      = 1'b0;
    logic             aresetn   = 1'b0;
    logic             cfg_we    = 1'b0;
    logic             cfg_index = CFG_BASE;
    logic [CFG_W-1:0] cfg_data  = '0;
    logic             s_tvalid  = 1'b0;
    logic             s_tready;
    logic [63:0]      s_tdata   = '0;   // [31:0] req_size, [63:32] release_addr
    logic [0:0]       s_tuser   = '0;   // [0] req_type
    logic             m_tvalid;
    logic             m_tready  = 1'b0;
    logic [31:0]      m_tdata;          // [31:0] granted_addr
    logic [1:0]       m_tuser;          // [1:0] status

    int          fail_count;
    int          pending;
    int          rx_hold_cycles = 0;
    int          quiet_cycles   = 0;
    bit          idle_on        = 1'b1;
    bit          stall_on       = 1'b1;
    bit          hold_phase     = 1'b0;
    bit          hold_started   = 1'b0;
    logic [31:0] cur_base       = BASE_RST;
    logic [15:0] cur_step       = STEP_RST;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    first_fit_block_allocator u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    ffba_checker u_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // receiver: random stalls, or one counted hold-off in the hold phase
    always @(posedge aclk) begin
        if (hold_phase && !hold_started) begin
            hold_started   <= 1'b1;
            m_tready       <= 1'b0;
            rx_hold_cycles <= RX_HOLD;
        end else if (rx_hold_cycles > 0) begin
            m_tready       <= 1'b0;
            rx_hold_cycles <= rx_hold_cycles - 1;
        end else begin
            m_tready <= !stall_on || ($urandom_range(99) >= 30);
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("first_fit_block_allocator verification failed");
            $finish;
        end
    end

    function automatic logic [31:0] block_start(int idx);
        logic [31:0] a;
        a = cur_base;
        for (int i = 0; i < idx; i++) a = a + 32'd1 + 32'(i) * 32'(cur_step);
        return a;
    endfunction

    task automatic offer_request(input req_t kind, input logic [31:0] want,
                                 input logic [31:0] rel);
        if (idle_on && $urandom_range(99) < 30) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 190)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {rel, want};
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending != 0);
    endtask

    task automatic program_layout(input logic [31:0] base, input logic [15:0] step);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_BASE;
        cfg_data  <= base;
        @(posedge aclk);
        cfg_index <= CFG_STEP;
        cfg_data  <= {16'd0, step};
        @(posedge aclk);
        cfg_we   <= 1'b0;
        cur_base = base;
        cur_step = step;
    endtask

    task automatic random_traffic(input int n);
        int          pick;
        int          blk;
        logic [31:0] want;
        logic [31:0] rel;
        logic [31:0] blen;
        for (int k = 0; k < n; k++) begin
            pick = $urandom_range(99);
            blk  = $urandom_range(BLOCK_COUNT - 1);
            blen = 32'd1 + 32'(blk) * 32'(cur_step);
            want = $urandom;
            rel  = $urandom;
            if (pick < 55) begin
                pick = $urandom_range(99);
                if (pick < 10) begin
                    want = '0;
                end else if (pick < 15) begin
                    want = '1;
                end else if (pick < 50 && pick >= 20) begin
                    // right at a block's size boundary
                    want = blen - 32'($urandom_range(1));
                end else if (pick >= 50) begin
                    want = $urandom_range(32'd1 + 32'(BLOCK_COUNT - 1) * 32'(cur_step));
                end
                offer_request(REQ_ALLOC, want, rel);
            end else begin
                pick = $urandom_range(99);
                if (pick < 70) begin
                    rel = block_start(blk);
                end else if (pick < 80) begin
                    rel = block_start(blk) + ($urandom_range(1) ? 32'd1 : 32'hFFFF_FFFF);
                end else if (pick >= 90) begin
                    rel = cur_base;
                end
                offer_request(REQ_FREE, want, rel);
            end
        end
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset layout: base 0, step 16
        offer_request(REQ_ALLOC, 32'd0, 32'd0);
        offer_request(REQ_ALLOC, 32'd0, 32'hFFFF_FFFF);
        offer_request(REQ_ALLOC, 32'd16, 32'd0);
        offer_request(REQ_ALLOC, 32'd17, 32'd0);
        offer_request(REQ_ALLOC, 32'hFFFF_FFFF, 32'd0);
        offer_request(REQ_ALLOC, 32'd1008, 32'd0);
        offer_request(REQ_ALLOC, 32'd1008, 32'd0);
        offer_request(REQ_FREE, 32'hFFFF_FFFF, block_start(BLOCK_COUNT - 1));
        offer_request(REQ_FREE, 32'd0, 32'd0);
        offer_request(REQ_FREE, 32'd0, 32'd0);
        offer_request(REQ_FREE, 32'd0, 32'd5);
        offer_request(REQ_FREE, 32'd0, 32'hFFFF_FFFF);
        offer_request(REQ_ALLOC, 32'd0, 32'd0);

        // unit blocks starting right below the top of the address space
        drain_results();
        program_layout(32'hFFFF_FFF0, 16'd0);
        offer_request(REQ_ALLOC, 32'd0, 32'd0);
        offer_request(REQ_ALLOC, 32'd1, 32'd0);
        offer_request(REQ_FREE, 32'd0, 32'hFFFF_FFF0);
        offer_request(REQ_FREE, 32'd0, 32'd0);
        offer_request(REQ_FREE, 32'd0, 32'hFFFF_FFF3);

        // widest step, base at the very top
        drain_results();
        program_layout(32'hFFFF_FFFF, 16'hFFFF);
        offer_request(REQ_ALLOC, 32'hFFFF_FFFF, 32'd0);
        offer_request(REQ_ALLOC, 32'd4128705, 32'd0);
        offer_request(REQ_FREE, 32'd0, block_start(BLOCK_COUNT - 1));
        offer_request(REQ_FREE, 32'd0, 32'hFFFF_FFFF);

        for (int p = 0; p < 6; p++) begin
            drain_results();
            case (p)
                0: program_layout(32'h0000_1000, 16'd1);
                1: program_layout($urandom, 16'($urandom));
                2: program_layout(32'hFFFF_FFFF, 16'hFFFF);
                3: program_layout(32'h0000_0000, 16'd0);
                4: program_layout($urandom, 16'($urandom_range(1, 64)));
                default: program_layout(32'h8000_0000, 16'd16);
            endcase
            idle_on    = (p != 3);
            stall_on   = (p != 3);
            hold_phase = (p == 1);
            random_traffic(ITEMS_PER_PHASE);
        end

        drain_results();
        repeat (BLOCK_COUNT + 8) @(posedge aclk);
        if (fail_count == 0 && pending == 0) begin
            $display("first_fit_block_allocator verification clean");
        end else begin
            $display("first_fit_block_allocator verification failed");
        end
        $finish;
    end

endmodule
